>>> hw/rtl/tdll_pkg.sv
// ============================================================================
// tdll_pkg
// Shared widths, operation codes and status codes of the task order deque.
// ============================================================================
`default_nettype none

package tdll_pkg;

    // Field widths
    localparam int OP_W   = 3;
    localparam int ID_W   = 4;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 5;

    // Largest slot count the task number field can name
    localparam int MAX_TASKS = 1 << ID_W;

    // Stream data widths, padded to whole bytes
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND_TAIL = 3'd0,
        OP_PUSH_HEAD   = 3'd1,
        OP_POP_HEAD    = 3'd2,
        OP_POP_TAIL    = 3'd3,
        OP_REMOVE      = 3'd4,
        OP_QUERY       = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK          = 2'd0,
        ST_EMPTY       = 2'd1,
        ST_NOT_PRESENT = 2'd2,
        ST_PRESENT     = 2'd3
    } t_status;

endpackage

`default_nettype wire

>>> hw/rtl/task_deque_linked_list.sv
// ============================================================================
// task_deque_linked_list
// Task order deque over a fixed set of slots, kept as a doubly linked list.
// ============================================================================
// Flow: a request is held in the request register, its result in the result register.
// Throughput: one request per cycle while results are drained; the list update
//   is a single combinational step between the request and result registers.
// Reset (synchronous, i_rst_n low): presence bits, head, tail, count and both
//   valid flags clear at once. Link arrays are not reset; they are written
//   whenever a task enters the list, before they are ever read.
`default_nettype none

module task_deque_linked_list #(
    parameter int NUM_SLOTS = 16                        // task slots, 2..256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    // Request side. tdata: op[2:0], task_id[6:3], zero[7]
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [tdll_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,

    // Result side. tdata: status[1:0], task_out[5:2], found[6],
    //                     count[11:7], zero[15:12]
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic [tdll_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata
);

    import tdll_pkg::*;

    // Slots beyond the reach of the task number field are never used.
    localparam int LP_DEPTH = (NUM_SLOTS < MAX_TASKS) ? NUM_SLOTS : MAX_TASKS;
    localparam int LP_IW    = $clog2(LP_DEPTH);
    localparam logic [8:0] LP_NUM_SLOTS = 9'(NUM_SLOTS);

    // ------------------------------------------------------------------
    // Request register
    // ------------------------------------------------------------------
    logic               r_in_vld;
    logic [OP_W-1:0]    r_in_op;
    logic [ID_W-1:0]    r_in_id;

    // ------------------------------------------------------------------
    // List state
    // ------------------------------------------------------------------
    logic [LP_IW-1:0]   r_next [LP_DEPTH];
    logic [LP_IW-1:0]   r_prev [LP_DEPTH];
    logic [LP_DEPTH-1:0] r_present;
    logic [LP_IW-1:0]   r_head;
    logic [LP_IW-1:0]   r_tail;
    logic [CNT_W-1:0]   r_count;

    logic [LP_IW-1:0]   n_next [LP_DEPTH];
    logic [LP_IW-1:0]   n_prev [LP_DEPTH];
    logic [LP_DEPTH-1:0] n_present;
    logic [LP_IW-1:0]   n_head;
    logic [LP_IW-1:0]   n_tail;
    logic [CNT_W-1:0]   n_count;

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic               r_out_vld;
    t_status            r_out_status;
    logic [ID_W-1:0]    r_out_task;
    logic               r_out_found;
    logic [CNT_W-1:0]   r_out_count;

    t_status            n_status;
    logic [ID_W-1:0]    n_task;

    // ------------------------------------------------------------------
    // Handshake: the request register moves on whenever the result
    // register is empty or being drained this cycle.
    // ------------------------------------------------------------------
    logic advance;
    logic in_accept;

    assign advance         = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // ------------------------------------------------------------------
    // Decode of the held request
    // ------------------------------------------------------------------
    logic               id_valid;
    logic [LP_IW-1:0]   idx;
    logic               here;
    logic [LP_IW-1:0]   rd_next_addr;
    logic [LP_IW-1:0]   rd_prev_addr;
    logic [LP_IW-1:0]   link_next;   // successor of the slot being taken
    logic [LP_IW-1:0]   link_prev;   // predecessor of the slot being taken
    logic               last_one;

    assign id_valid = {5'd0, r_in_id} < LP_NUM_SLOTS;
    assign idx      = r_in_id[LP_IW-1:0];
    assign here     = id_valid && r_present[idx];
    assign last_one = (r_count == CNT_W'(1));

    // One read address per link array: pops read at an end, remove at the
    // named slot (which is also the end when the named slot is head or tail).
    assign rd_next_addr = (r_in_op == OP_POP_HEAD) ? r_head : idx;
    assign rd_prev_addr = (r_in_op == OP_POP_TAIL) ? r_tail : idx;
    assign link_next    = r_next[rd_next_addr];
    assign link_prev    = r_prev[rd_prev_addr];

    // ------------------------------------------------------------------
    // Single-step list update
    // ------------------------------------------------------------------
    always_comb begin
        n_next    = r_next;
        n_prev    = r_prev;
        n_present = r_present;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_status  = ST_OK;
        n_task    = '0;

        unique case (r_in_op)
            OP_APPEND_TAIL, OP_PUSH_HEAD: begin
                if (!id_valid) begin
                    n_status = ST_NOT_PRESENT;
                end else if (here) begin
                    n_status = ST_PRESENT;
                end else begin
                    if (r_count == '0) begin
                        n_head      = idx;
                        n_tail      = idx;
                        n_next[idx] = '0;
                        n_prev[idx] = '0;
                    end else if (r_in_op == OP_APPEND_TAIL) begin
                        n_next[r_tail] = idx;
                        n_prev[idx]    = r_tail;
                        n_next[idx]    = '0;
                        n_tail         = idx;
                    end else begin
                        n_prev[r_head] = idx;
                        n_next[idx]    = r_head;
                        n_prev[idx]    = '0;
                        n_head         = idx;
                    end
                    n_present[idx] = 1'b1;
                    n_count        = r_count + CNT_W'(1);
                end
            end
            OP_POP_HEAD: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_present[r_head] = 1'b0;
                    n_count           = r_count - CNT_W'(1);
                    n_task            = ID_W'(r_head);
                    n_head            = last_one ? '0 : link_next;
                    if (last_one) begin
                        n_tail = '0;
                    end
                end
            end
            OP_POP_TAIL: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_present[r_tail] = 1'b0;
                    n_count           = r_count - CNT_W'(1);
                    n_task            = ID_W'(r_tail);
                    n_tail            = last_one ? '0 : link_prev;
                    if (last_one) begin
                        n_head = '0;
                    end
                end
            end
            OP_REMOVE: begin
                if (!here) begin
                    n_status = ST_NOT_PRESENT;
                end else begin
                    n_present[idx] = 1'b0;
                    n_count        = r_count - CNT_W'(1);
                    n_task         = r_in_id;
                    if (last_one) begin
                        n_head = '0;
                        n_tail = '0;
                    end else if (idx == r_head) begin
                        n_head = link_next;
                    end else if (idx == r_tail) begin
                        n_tail = link_prev;
                    end else begin
                        // middle slot: splice neighbors together
                        n_next[link_prev] = link_next;
                        n_prev[link_next] = link_prev;
                    end
                end
            end
            OP_QUERY: begin
                n_status = here ? ST_OK : ST_NOT_PRESENT;
            end
            default: begin
                // unused codes: no change, plain ok
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op <= i_s_axis_tdata[OP_W-1:0];
            r_in_id <= i_s_axis_tdata[OP_W+ID_W-1:OP_W];
        end
        if (advance) begin
            r_next       <= n_next;
            r_prev       <= n_prev;
            r_out_status <= n_status;
            r_out_task   <= n_task;
            r_out_found  <= here;
            r_out_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_present <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
        end else begin
            if (in_accept) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_present <= n_present;
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_count   <= n_count;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {4'd0, r_out_count, r_out_found, r_out_task, r_out_status};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_matches_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_present) == int'(r_count))
        else $error("task count disagrees with presence bits");

    a_empty_ends_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == '0 && r_tail == '0))
        else $error("empty list with nonzero head or tail");

    a_single_head_is_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(1)) |-> (r_head == r_tail))
        else $error("one task but head and tail differ");

    a_ends_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_present[r_head] && r_present[r_tail]))
        else $error("head or tail slot not marked present");

    a_result_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld)
        else $error("processed request produced no result");

endmodule

`default_nettype wire

>>> tb/tb_task_deque_linked_list.sv
// ============================================================================
// tb_task_deque_linked_list
// Self-checking bench for the task order deque: a directed table, then
// random fill/drain/noise traffic, with every result checked in order
// against a cycle-free model of the linked list or a hand-written value.
// ============================================================================
`default_nettype none

module tb_task_deque_linked_list;

    import tdll_pkg::*;

    localparam int SLOTS      = MAX_TASKS;
    localparam int RAND_ITEMS = 1800;
    localparam int MAX_IDLE   = 17;
    localparam int HOLD_AT    = 600;   // results seen before the long output stall
    localparam int HOLD_LEN   = 400;   // cycles the result side stays not ready
    localparam int SHOW_MAX   = 10;

    // Op codes the block accepts but does nothing with
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    // Laid out so that bits [11:0] of the result tdata map straight onto it
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             found;
        logic [ID_W-1:0]  task_out;
        t_status          status;
    } deque_result_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  id;
        bit               typed;     // 1: result below is written out by hand
        t_status          st;
        logic [ID_W-1:0]  tout;
        logic             fnd;
        logic [CNT_W-1:0] cnt;
    } dir_row_t;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_NOISE} stim_mode_t;

    localparam int DIR_ROWS = 25;

    // Hand-written results only where they are obvious; the rest are predicted
    dir_row_t directed_tbl [DIR_ROWS] = '{
        '{OP_POP_HEAD,    4'd0,  1'b1, ST_EMPTY,       4'd0, 1'b0, 5'd0},
        '{OP_POP_TAIL,    4'd15, 1'b1, ST_EMPTY,       4'd0, 1'b0, 5'd0},
        '{OP_REMOVE,      4'd7,  1'b1, ST_NOT_PRESENT, 4'd0, 1'b0, 5'd0},
        '{OP_QUERY,       4'd15, 1'b1, ST_NOT_PRESENT, 4'd0, 1'b0, 5'd0},
        '{OP_SPARE_6,     4'd9,  1'b1, ST_OK,          4'd0, 1'b0, 5'd0},
        '{OP_SPARE_7,     4'd15, 1'b1, ST_OK,          4'd0, 1'b0, 5'd0},
        '{OP_APPEND_TAIL, 4'd0,  1'b1, ST_OK,          4'd0, 1'b0, 5'd1},
        '{OP_APPEND_TAIL, 4'd0,  1'b1, ST_PRESENT,     4'd0, 1'b1, 5'd1},
        '{OP_PUSH_HEAD,   4'd15, 1'b0, ST_OK,          4'd0, 1'b0, 5'd0},
        '{OP_PUSH_HEAD,   4'd15, 1'b0, ST_OK,          4'd0, 1'b0, 5'd0},
        '{OP_APPEND_TAIL, 4'd5,  1'b0, ST_OK,          4'd0, 1'b0, 5'd0},
        '{OP_APPEND_TAIL, 4'd10, 1'b0, ST_OK,          4'd0, 1'b0, 5'd0},
        '{OP_QUERY,       4'd5,  1'b0, ST_OK,          4'd0, 1'b0, 5'd0},
        '{OP_POP_HEAD,    4'd3,  1'b0, ST_OK,          4'd0, 1'b0, 5'd0},
        '{OP_PUSH_HEAD,   4'd15, 1'b0, ST_OK,          4'd0, 1'b0, 5'd0},
        '{OP_REMOVE,      4'd0,  1'b0, ST_OK,          4'd0, 1'b0, 5'd0},  // middle
        '{OP_REMOVE,      4'd15, 1'b0, ST_OK,          4'd0, 1'b0, 5'd0},  // head
        '{OP_REMOVE,      4'd10, 1'b0, ST_OK,          4'd0, 1'b0, 5'd0},  // tail
        '{OP_QUERY,       4'd10, 1'b0, ST_OK,          4'd0, 1'b0, 5'd0},
        '{OP_POP_TAIL,    4'd5,  1'b0, ST_OK,          4'd0, 1'b0, 5'd0},  // empties
        '{OP_PUSH_HEAD,   4'd9,  1'b0, ST_OK,          4'd0, 1'b0, 5'd0},
        '{OP_POP_TAIL,    4'd9,  1'b0, ST_OK,          4'd0, 1'b0, 5'd0},
        '{OP_APPEND_TAIL, 4'd3,  1'b0, ST_OK,          4'd0, 1'b0, 5'd0},
        '{OP_REMOVE,      4'd3,  1'b0, ST_OK,          4'd0, 1'b0, 5'd0},  // lone task
        '{OP_SPARE_7,     4'd0,  1'b0, ST_OK,          4'd0, 1'b0, 5'd0}
    };

    // ---------------------------------------------------------------- DUT I/O
    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_data  = '0;    // op[2:0], task_id[6:3], zero[7]
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;          // status, task_out, found, count

    always #5 i_clk = ~i_clk;

    task_deque_linked_list #(
        .NUM_SLOTS (SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    // ------------------------------------------------------ list shadow state
    logic [ID_W-1:0]  lnk_next [SLOTS];
    logic [ID_W-1:0]  lnk_prev [SLOTS];
    logic             in_list  [SLOTS];
    logic [ID_W-1:0]  list_head = '0;
    logic [ID_W-1:0]  list_tail = '0;
    logic [CNT_W-1:0] list_len  = '0;

    deque_result_t pending_results [$];

    int  mismatches      = 0;
    int  results_checked = 0;
    int  requests_sent   = 0;
    int  full_hits       = 0;
    int  stall_cycles    = 0;   // cycles the request side saw tready low
    int  op_hist [8];
    bit  tx_burst  = 1'b0;      // request side runs without gaps
    bit  rx_burst  = 1'b0;      // result side runs without stalls
    bit  hold_on   = 1'b0;
    bit  hold_done = 1'b0;

    initial begin
        for (int i = 0; i < SLOTS; i++) in_list[i] = 1'b0;
        for (int i = 0; i < 8; i++) op_hist[i] = 0;
    end

    // Unlink the head; an emptied list parks both ends at slot zero
    function automatic logic [ID_W-1:0] take_head();
        logic [ID_W-1:0] s;
        s = list_head;
        in_list[s] = 1'b0;
        list_len--;
        if (list_len == 0) begin
            list_head = '0;
            list_tail = '0;
        end else begin
            list_head = lnk_next[s];
        end
        return s;
    endfunction

    function automatic logic [ID_W-1:0] take_tail();
        logic [ID_W-1:0] s;
        s = list_tail;
        in_list[s] = 1'b0;
        list_len--;
        if (list_len == 0) begin
            list_head = '0;
            list_tail = '0;
        end else begin
            list_tail = lnk_prev[s];
        end
        return s;
    endfunction

    // Applies one request to the shadow list and returns the result it gives
    function automatic deque_result_t deque_apply(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
        deque_result_t r;
        logic          here;
        logic [ID_W-1:0] p, n;
        here       = in_list[id];
        r.status   = ST_OK;
        r.task_out = '0;
        r.found    = here;
        case (op)
            OP_APPEND_TAIL, OP_PUSH_HEAD: begin
                if (here) begin
                    r.status = ST_PRESENT;
                end else begin
                    if (list_len == 0) begin
                        list_head    = id;
                        list_tail    = id;
                        lnk_next[id] = '0;
                        lnk_prev[id] = '0;
                    end else if (op == OP_APPEND_TAIL) begin
                        lnk_prev[id]        = list_tail;
                        lnk_next[id]        = '0;
                        lnk_next[list_tail] = id;
                        list_tail           = id;
                    end else begin
                        lnk_next[id]        = list_head;
                        lnk_prev[id]        = '0;
                        lnk_prev[list_head] = id;
                        list_head           = id;
                    end
                    in_list[id] = 1'b1;
                    list_len++;
                end
            end
            OP_POP_HEAD, OP_POP_TAIL: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else r.task_out = (op == OP_POP_HEAD) ? take_head() : take_tail();
            end
            OP_REMOVE: begin
                if (!here) begin
                    r.status = ST_NOT_PRESENT;
                end else if (id == list_head) begin
                    r.task_out = take_head();
                end else if (id == list_tail) begin
                    r.task_out = take_tail();
                end else begin
                    p = lnk_prev[id];
                    n = lnk_next[id];
                    lnk_next[p] = n;
                    lnk_prev[n] = p;
                    in_list[id] = 1'b0;
                    list_len--;
                    r.task_out = id;
                end
            end
            OP_QUERY: r.status = here ? ST_OK : ST_NOT_PRESENT;
            default: ;
        endcase
        r.count = list_len;
        return r;
    endfunction

    // Random slot that is (or is not) in the list; caller makes sure one exists
    function automatic logic [ID_W-1:0] pick_slot(bit want_present);
        int start;
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++) begin
            if (in_list[(start + k) % SLOTS] == want_present) return ID_W'((start + k) % SLOTS);
        end
        return ID_W'(start);
    endfunction

    task automatic report_bad(input string what);
        mismatches++;
        if (mismatches <= SHOW_MAX) $display("[%0t] %s", $realtime, what);
    endtask

    // Offer one request from a falling edge, hold it until taken, then predict.
    // Returns at the falling edge after acceptance.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                input bit typed, input deque_result_t typed_res);
        int            gap;
        deque_result_t predicted;
        gap = (tx_burst || hold_on) ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_data  = {1'b0, id, op};
        forever begin
            @(posedge i_clk);
            if (s_ready) break;
            stall_cycles++;
        end
        predicted = deque_apply(op, id);
        pending_results.push_back(typed ? typed_res : predicted);
        requests_sent++;
        op_hist[op]++;
        if (list_len == SLOTS) full_hits++;
        if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------ result side
    initial begin : result_side
        deque_result_t got;
        deque_result_t want;
        int            stall;
        @(posedge i_rst_n);
        forever begin
            // One long stall so the block backs up and drops tready
            if (!hold_done && results_checked >= HOLD_AT) begin
                hold_on = 1'b1;
                m_ready = 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
                hold_on   = 1'b0;
                hold_done = 1'b1;
            end
            stall = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_ready = 1'b1;
            do @(posedge i_clk); while (!m_valid);
            got = deque_result_t'(m_data[11:0]);
            if (pending_results.size() == 0) begin
                report_bad($sformatf("result %h with no request outstanding", m_data));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.task_out !== want.task_out ||
                    got.found !== want.found || got.count !== want.count) begin
                    report_bad($sformatf(
                        "result %0d: exp st=%0d out=%0d found=%0d cnt=%0d, got st=%0d out=%0d found=%0d cnt=%0d",
                        results_checked, want.status, want.task_out, want.found, want.count,
                        got.status, got.task_out, got.found, got.count));
                end
            end
            results_checked++;
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
            @(negedge i_clk);
        end
    end

    // ----------------------------------------------------------- request side
    initial begin : stimulus
        deque_result_t   typed_res;
        stim_mode_t      mode;
        int              noise_left;
        int              roll;
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        mode       = MODE_FILL;
        noise_left = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table
        foreach (directed_tbl[i]) begin
            typed_res.status   = directed_tbl[i].st;
            typed_res.task_out = directed_tbl[i].tout;
            typed_res.found    = directed_tbl[i].fnd;
            typed_res.count    = directed_tbl[i].cnt;
            send_request(directed_tbl[i].op, directed_tbl[i].id, directed_tbl[i].typed,
                         typed_res);
        end

        // Random traffic: mostly fill-to-full and drain-to-empty sweeps,
        // with bursts of unconstrained noise in between
        typed_res = '0;
        for (int k = 0; k < RAND_ITEMS; k++) begin
            case (mode)
                MODE_FILL: begin
                    if (list_len == SLOTS || $urandom_range(0, 39) == 0) mode = MODE_DRAIN;
                end
                MODE_DRAIN: begin
                    if (list_len == 0 && $urandom_range(0, 3) == 0) begin
                        mode       = MODE_NOISE;
                        noise_left = $urandom_range(5, 30);
                    end else if (list_len == 0 || $urandom_range(0, 39) == 0) begin
                        mode = MODE_FILL;
                    end
                end
                default: begin
                    if (noise_left == 0) mode = MODE_FILL;
                    else noise_left--;
                end
            endcase

            roll = $urandom_range(0, 9);
            id   = ID_W'($urandom_range(0, SLOTS - 1));
            case (mode)
                MODE_FILL: begin
                    if (roll < 7) begin
                        op = $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_APPEND_TAIL;
                        if (list_len < SLOTS) id = pick_slot(1'b0);
                    end else if (roll == 7) begin
                        op = $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_APPEND_TAIL;
                    end else if (roll == 8) begin
                        op = OP_QUERY;
                    end else begin
                        op = OP_W'($urandom_range(OP_POP_HEAD, OP_REMOVE));
                        if (op == OP_REMOVE && list_len > 0) id = pick_slot(1'b1);
                    end
                end
                MODE_DRAIN: begin
                    if (roll < 7) begin
                        op = OP_W'($urandom_range(OP_POP_HEAD, OP_REMOVE));
                        if (list_len > 0) id = pick_slot(1'b1);
                    end else if (roll == 7) begin
                        op = OP_REMOVE;
                    end else if (roll == 8) begin
                        op = OP_QUERY;
                    end else begin
                        op = OP_APPEND_TAIL;
                        if (list_len < SLOTS) id = pick_slot(1'b0);
                    end
                end
                default: op = OP_W'($urandom_range(0, 7));
            endcase
            send_request(op, id, 1'b0, typed_res);
        end
        s_valid = 1'b0;

        // Drain, then wait out any stray result
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Ran %0d requests (%0d directed); per op 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 requests_sent, DIR_ROWS, op_hist[0], op_hist[1], op_hist[2], op_hist[3],
                 op_hist[4], op_hist[5], op_hist[6], op_hist[7]);
        $display("List full %0d times, request side stalled %0d cycles, %0d results, %0d bad",
                 full_hits, stall_cycles, results_checked, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: well above the slowest legal run (every request and result
    // at the longest idle, plus the long output stall)
    initial begin : watchdog
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/tdll_pkg.sv
hw/rtl/task_deque_linked_list.sv
tb/tb_task_deque_linked_list.sv
